### hdl/bofg_pkg.sv
// ----------------------------------------------------------------------------
// bofg_pkg
// Shared types, register indexes and constants of the on/off flit source.
// ----------------------------------------------------------------------------
package bofg_pkg;

    // default sizing of the network
    localparam int unsigned DEF_NUM_VCS          = 4;
    localparam int unsigned DEF_NUM_NODES        = 1024;
    localparam int unsigned DEF_NODES_PER_ROUTER = 4;

    // fixed-point reciprocals used for the constant divisions
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_W     = 25;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TO_ON      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TO_OFF      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLITS_PER_PKT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID      = 4'd3;

    // packet length limits
    localparam logic [4:0] MIN_FLITS = 5'd1;
    localparam logic [4:0] MAX_FLITS = 5'd16;

    // register reset values
    localparam logic [16:0] RST_ON_TO_OFF = 17'h10000;

    typedef struct packed {
        logic [16:0] off_to_on_threshold;
        logic [16:0] on_to_off_threshold;
        logic [4:0]  flits_per_packet;
        logic [9:0]  source_id;
    } cfg_regs_t;

    // one tick, with the destination decode filled in along the pipeline
    typedef struct packed {
        logic        slot_open;
        logic [15:0] random_first;
        logic [15:0] random_second;
        logic [7:0]  credit_ok;
        logic [31:0] packet_count;
        logic [31:0] flit_count;
        logic [9:0]  new_dest;
        logic [9:0]  dest_quot;
        logic [12:0] vc_quot;
        logic [9:0]  dest;
        logic [2:0]  vc;
        logic [7:0]  router;
    } item_t;

    typedef struct packed {
        logic        flit_valid;
        logic        head;
        logic        tail;
        logic [3:0]  flit_position;
        logic [9:0]  dest_node;
        logic [7:0]  dest_router;
        logic [2:0]  virtual_channel;
        logic [31:0] packet_id;
        logic [31:0] flit_id;
        logic [9:0]  source_node;
        logic        burst_started;
    } result_t;

endpackage

### hdl/bofg_tick_if.sv
// ----------------------------------------------------------------------------
// bofg_tick_if
// Per-cycle stimulus channel of the flit source.
// ----------------------------------------------------------------------------
interface bofg_tick_if;

    logic        valid;
    logic        ready;
    logic        slot_open;
    logic [15:0] random_first;
    logic [15:0] random_second;
    logic [9:0]  new_dest;
    logic [7:0]  credit_ok;
    logic [31:0] packet_count_in;
    logic [31:0] flit_count_in;

    modport source
    (
        output valid, slot_open, random_first, random_second, new_dest, credit_ok,
               packet_count_in, flit_count_in,
        input  ready
    );

    modport sink
    (
        input  valid, slot_open, random_first, random_second, new_dest, credit_ok,
               packet_count_in, flit_count_in,
        output ready
    );

endinterface

### hdl/bofg_flit_if.sv
// ----------------------------------------------------------------------------
// bofg_flit_if
// Result channel: one flit slot per tick.
// ----------------------------------------------------------------------------
interface bofg_flit_if;

    logic        valid;
    logic        ready;
    logic        flit_valid;
    logic        head;
    logic        tail;
    logic [3:0]  flit_position;
    logic [9:0]  dest_node;
    logic [7:0]  dest_router;
    logic [2:0]  virtual_channel;
    logic [31:0] packet_id;
    logic [31:0] flit_id;
    logic [9:0]  source_node;
    logic        burst_started;

    modport source
    (
        output valid, flit_valid, head, tail, flit_position, dest_node, dest_router,
               virtual_channel, packet_id, flit_id, source_node, burst_started,
        input  ready
    );

    modport sink
    (
        input  valid, flit_valid, head, tail, flit_position, dest_node, dest_router,
               virtual_channel, packet_id, flit_id, source_node, burst_started,
        output ready
    );

endinterface

### hdl/bofg_cfg_if.sv
// ----------------------------------------------------------------------------
// bofg_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bofg_cfg_if;

    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [16:0] data;

    modport source
    (
        output valid, index, data,
        input  ready
    );

    modport sink
    (
        input  valid, index, data,
        output ready
    );

endinterface

### hdl/bursty_onoff_flit_generator_core.sv
// ----------------------------------------------------------------------------
// bursty_onoff_flit_generator_core
// Two-state on/off bursty flit source for one network node.
// Path: a tick's result passes the input register, two destination decode
// stages and the result register before it is shown.
// Throughput: one tick per cycle while the flit channel does not stall.
// Reset: burst off, no destination, registers at their reset values.
// ----------------------------------------------------------------------------
module bursty_onoff_flit_generator_core #(
    parameter int unsigned NUM_VCS          = bofg_pkg::DEF_NUM_VCS,
    parameter int unsigned NUM_NODES        = bofg_pkg::DEF_NUM_NODES,
    parameter int unsigned NODES_PER_ROUTER = bofg_pkg::DEF_NODES_PER_ROUTER
) (
    input  logic         clk,
    input  logic         rst_n,
    bofg_tick_if.sink    tick,
    bofg_flit_if.source  flit,
    bofg_cfg_if.sink     cfg
);

    import bofg_pkg::*;

    cfg_regs_t cfg_regs_reg;
    item_t     in_item;
    item_t     dec_item;
    logic      dec_valid;
    logic      dec_take;
    result_t   res;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.off_to_on_threshold <= '0;
            cfg_regs_reg.on_to_off_threshold <= RST_ON_TO_OFF;
            cfg_regs_reg.flits_per_packet    <= MIN_FLITS;
            cfg_regs_reg.source_id           <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_OFF_TO_ON:     cfg_regs_reg.off_to_on_threshold <= cfg.data;
                CFG_ON_TO_OFF:     cfg_regs_reg.on_to_off_threshold <= cfg.data;
                CFG_FLITS_PER_PKT: cfg_regs_reg.flits_per_packet    <= cfg.data[4:0];
                CFG_SOURCE_ID:     cfg_regs_reg.source_id           <= cfg.data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // gather the tick payload
    always_comb
    begin
        in_item               = '0;
        in_item.slot_open     = tick.slot_open;
        in_item.random_first  = tick.random_first;
        in_item.random_second = tick.random_second;
        in_item.credit_ok     = tick.credit_ok;
        in_item.packet_count  = tick.packet_count_in;
        in_item.flit_count    = tick.flit_count_in;
        in_item.new_dest      = tick.new_dest;
    end

    bofg_dest_decode #(
        .NUM_VCS          (NUM_VCS),
        .NUM_NODES        (NUM_NODES),
        .NODES_PER_ROUTER (NODES_PER_ROUTER)
    ) u_dest_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .in_item   (in_item),
        .dec_valid (dec_valid),
        .dec_take  (dec_take),
        .dec_item  (dec_item)
    );

    bofg_source_step u_source_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_regs_reg),
        .item_valid (dec_valid),
        .item_take  (dec_take),
        .item       (dec_item),
        .res_valid  (flit.valid),
        .res_ready  (flit.ready),
        .res        (res)
    );

    // result fields onto the flit channel
    assign flit.flit_valid      = res.flit_valid;
    assign flit.head            = res.head;
    assign flit.tail            = res.tail;
    assign flit.flit_position   = res.flit_position;
    assign flit.dest_node       = res.dest_node;
    assign flit.dest_router     = res.dest_router;
    assign flit.virtual_channel = res.virtual_channel;
    assign flit.packet_id       = res.packet_id;
    assign flit.flit_id         = res.flit_id;
    assign flit.source_node     = res.source_node;
    assign flit.burst_started   = res.burst_started;

endmodule

### hdl/bofg_dest_decode.sv
// ----------------------------------------------------------------------------
// bofg_dest_decode
// Input register and staged decode of the offered destination into
// node, injection VC and router number, with stall propagation.
// ----------------------------------------------------------------------------
module bofg_dest_decode #(
    parameter int unsigned NUM_VCS          = bofg_pkg::DEF_NUM_VCS,
    parameter int unsigned NUM_NODES        = bofg_pkg::DEF_NUM_NODES,
    parameter int unsigned NODES_PER_ROUTER = bofg_pkg::DEF_NODES_PER_ROUTER
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bofg_pkg::item_t in_item,
    output logic            dec_valid,
    input  logic            dec_take,
    output bofg_pkg::item_t dec_item
);

    import bofg_pkg::*;

    localparam int unsigned NODE_RECIP   =
        ((1 << RECIP_SHIFT) + NUM_NODES - 1) / NUM_NODES;
    localparam int unsigned ROUTER_RECIP =
        ((1 << RECIP_SHIFT) + NODES_PER_ROUTER - 1) / NODES_PER_ROUTER;

    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    item_t s1_reg, s2_reg, s3_reg;
    item_t s1_next, s2_next, s3_next;
    logic  free1, free2, free3;

    logic [12:0]          nd_scaled;
    logic [RECIP_W+9:0]   dq_prod;
    logic [RECIP_W+12:0]  vq_prod;
    logic [19:0]          qn;
    logic [12:0]          qv;
    logic [RECIP_W+9:0]   rt_prod;

    // stall chain: a stage may load when it is empty or its item moves on
    assign free3    = !s3_valid_reg || dec_take;
    assign free2    = !s2_valid_reg || free3;
    assign free1    = !s1_valid_reg || free2;
    assign in_ready = free1;

    // quotients by the node count, taken from the port
    always_comb
    begin
        nd_scaled = 13'(in_item.new_dest) * 13'(NUM_VCS);
        dq_prod   = (RECIP_W+10)'(in_item.new_dest) * (RECIP_W+10)'(NODE_RECIP);
        vq_prod   = (RECIP_W+13)'(nd_scaled) * (RECIP_W+13)'(NODE_RECIP);
        s1_next           = in_item;
        s1_next.dest_quot = 10'(dq_prod >> RECIP_SHIFT);
        s1_next.vc_quot   = 13'(vq_prod >> RECIP_SHIFT);
    end

    // remainder gives the node, quotient difference gives the vc
    always_comb
    begin
        qn = 20'(s1_reg.dest_quot) * 20'(NUM_NODES);
        qv = 13'(s1_reg.dest_quot) * 13'(NUM_VCS);
        s2_next      = s1_reg;
        s2_next.dest = 10'(20'(s1_reg.new_dest) - qn);
        s2_next.vc   = 3'(s1_reg.vc_quot - qv);
    end

    // router number of the decoded node
    always_comb
    begin
        rt_prod = (RECIP_W+10)'(s2_reg.dest) * (RECIP_W+10)'(ROUTER_RECIP);
        s3_next        = s2_reg;
        s3_next.router = 8'(rt_prod >> RECIP_SHIFT);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (free2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (free3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (free1 && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (free2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (free3 && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign dec_valid = s3_valid_reg;
    assign dec_item  = s3_reg;

endmodule

### hdl/bofg_source_step.sv
// ----------------------------------------------------------------------------
// bofg_source_step
// On/off burst state, flit position and packet latches; builds one result
// per tick into the result register.
// ----------------------------------------------------------------------------
module bofg_source_step (
    input  logic              clk,
    input  logic              rst_n,
    input  bofg_pkg::cfg_regs_t cfg_regs,
    input  logic              item_valid,
    output logic              item_take,
    input  bofg_pkg::item_t   item,
    output logic              res_valid,
    input  logic              res_ready,
    output bofg_pkg::result_t res
);

    import bofg_pkg::*;

    logic        injecting_reg, injecting_next;
    logic [9:0]  cur_dest_reg, cur_dest_next;
    logic [2:0]  cur_vc_reg, cur_vc_next;
    logic [7:0]  cur_router_reg, cur_router_next;
    logic [3:0]  flit_index_reg, flit_index_next;
    logic [7:0]  latched_router_reg, latched_router_next;
    logic [31:0] latched_packet_id_reg, latched_packet_id_next;
    logic        res_valid_reg;
    result_t     res_reg, res_next;

    logic [4:0]  pkt_len;
    logic        fire;
    logic        begin_burst;
    logic        vc_ok_old;
    logic [3:0]  pos;
    logic        emit;
    logic        is_head;
    logic        is_tail;

    // a tick moves on when the result register is free or being drained
    assign item_take = !res_valid_reg || res_ready;
    assign fire      = item_valid && item_take;

    // packet length clamped to one..sixteen
    always_comb
    begin
        if (cfg_regs.flits_per_packet == 5'd0)
        begin
            pkt_len = MIN_FLITS;
        end
        else if (cfg_regs.flits_per_packet > MAX_FLITS)
        begin
            pkt_len = MAX_FLITS;
        end
        else
        begin
            pkt_len = cfg_regs.flits_per_packet;
        end
    end

    // burst decision, then flit emission
    always_comb
    begin
        injecting_next = injecting_reg;
        begin_burst    = 1'b0;
        vc_ok_old      = item.credit_ok[cur_vc_reg];

        if (item.slot_open)
        begin
            if (!injecting_reg)
            begin
                if ({1'b0, item.random_first} < cfg_regs.off_to_on_threshold)
                begin
                    injecting_next = 1'b1;
                    begin_burst    = 1'b1;
                end
            end
            else if (vc_ok_old)
            begin
                if ({1'b0, item.random_first} < cfg_regs.on_to_off_threshold)
                begin
                    if ({1'b0, item.random_second} < cfg_regs.off_to_on_threshold)
                    begin
                        begin_burst = 1'b1;
                    end
                    else
                    begin
                        injecting_next = 1'b0;
                    end
                end
            end
        end

        cur_dest_next   = begin_burst ? item.dest   : cur_dest_reg;
        cur_vc_next     = begin_burst ? item.vc     : cur_vc_reg;
        cur_router_next = begin_burst ? item.router : cur_router_reg;

        // stale position after a length change restarts the packet
        pos = ({1'b0, flit_index_reg} >= pkt_len) ? 4'd0 : flit_index_reg;

        emit    = (pos != 4'd0)
                  || (item.slot_open && injecting_next && item.credit_ok[cur_vc_next]);
        is_head = (pos == 4'd0);
        is_tail = ({1'b0, pos} == (pkt_len - 5'd1));

        latched_router_next    = latched_router_reg;
        latched_packet_id_next = latched_packet_id_reg;
        flit_index_next        = pos;
        if (emit)
        begin
            if (is_head)
            begin
                latched_router_next    = cur_router_next;
                latched_packet_id_next = item.packet_count;
            end
            flit_index_next = is_tail ? 4'd0 : pos + 4'd1;
        end

        res_next               = '0;
        res_next.burst_started = begin_burst;
        if (emit)
        begin
            res_next.flit_valid      = 1'b1;
            res_next.head            = is_head;
            res_next.tail            = is_tail;
            res_next.flit_position   = pos;
            res_next.dest_node       = cur_dest_next;
            res_next.dest_router     = latched_router_next;
            res_next.virtual_channel = cur_vc_next;
            res_next.packet_id       = latched_packet_id_next;
            res_next.flit_id         = item.flit_count;
            res_next.source_node     = cfg_regs.source_id;
        end
    end

    // source state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            injecting_reg         <= 1'b0;
            cur_dest_reg          <= '0;
            cur_vc_reg            <= '0;
            cur_router_reg        <= '0;
            flit_index_reg        <= '0;
            latched_router_reg    <= '0;
            latched_packet_id_reg <= '0;
        end
        else if (fire)
        begin
            injecting_reg         <= injecting_next;
            cur_dest_reg          <= cur_dest_next;
            cur_vc_reg            <= cur_vc_next;
            cur_router_reg        <= cur_router_next;
            flit_index_reg        <= flit_index_next;
            latched_router_reg    <= latched_router_next;
            latched_packet_id_reg <= latched_packet_id_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            res_valid_reg <= item_valid;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
